/* rtl/core/two_foot_pd_step_tracker_core_defines.svh */
`ifndef TWO_FOOT_PD_STEP_TRACKER_CORE_DEFINES_SVH
`define TWO_FOOT_PD_STEP_TRACKER_CORE_DEFINES_SVH

// same-cycle implication
`define TFPD_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("tfpd assertion failed");

// next-cycle implication
`define TFPD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("tfpd assertion failed");

`endif

/* rtl/core/tfpd_pkg.sv */
package tfpd_pkg;

  typedef enum logic [1:0] {
    OP_SET_MODE    = 2'd0,
    OP_SET_TARGETS = 2'd1,
    OP_TICK        = 2'd2,
    OP_NOP         = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CFG_KP_HOLD          = 3'd0,
    CFG_KD_HOLD          = 3'd1,
    CFG_KP_TRACK         = 3'd2,
    CFG_KD_TRACK         = 3'd3,
    CFG_STEP_TIME        = 3'd4,
    CFG_POSITION_LIMIT   = 3'd5,
    CFG_COLLISION_MARGIN = 3'd6,
    CFG_AXIS_IS_X        = 3'd7
  } cfg_idx_e;

  localparam logic [31:0] KP_HOLD_RST          = 32'd1030553600;
  localparam logic [31:0] KD_HOLD_RST          = 32'd13565952;
  localparam logic [31:0] KP_TRACK_RST         = 32'd10538189;
  localparam logic [31:0] KD_TRACK_RST         = 32'd1146880;
  localparam logic [31:0] STEP_TIME_RST        = 32'd17179869;
  localparam logic [30:0] POSITION_LIMIT_RST   = 31'd838861;
  localparam logic [30:0] COLLISION_MARGIN_RST = 31'd671089;

  localparam logic [31:0] POS_MAX = 32'h7fff_ffff;
  localparam logic [31:0] POS_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_TGT,
    ST_EMIT
  } ctl_state_e;

  typedef enum logic [3:0] {
    LS_IDLE,
    LS_ERR,
    LS_MP,
    LS_MD,
    LS_ACC,
    LS_MAG,
    LS_DVL,
    LS_DVH,
    LS_VEL,
    LS_DP,
    LS_POS
  } lane_step_e;

  typedef enum logic [1:0] {
    TS_IDLE,
    TS_CLAMP,
    TS_SEP,
    TS_ADJ
  } tgt_step_e;

  typedef struct packed {
    logic        start;
    logic [31:0] kp;
    logic [31:0] kd;
  } lane_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lane_sts_t;

  typedef struct packed {
    logic load;
    logic copy_right;
    logic copy_left;
    logic right_tracking;
    logic left_tracking;
  } tgt_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } tgt_sts_t;

endpackage

/* rtl/core/tfpd_in_if.sv */
interface tfpd_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic               foot;
  logic               mode;
  logic signed [31:0] target_right;
  logic signed [31:0] target_left;

  modport source (output valid, output opcode, output foot, output mode,
                  output target_right, output target_left, input ready);
  modport sink (input valid, input opcode, input foot, input mode,
                input target_right, input target_left, output ready);
endinterface

/* rtl/core/tfpd_out_if.sv */
interface tfpd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_right;
  logic signed [31:0] pos_left;

  modport source (output valid, output pos_right, output pos_left, input ready);
  modport sink (input valid, input pos_right, input pos_left, output ready);
endinterface

/* rtl/core/tfpd_lane.sv */
module tfpd_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tfpd_pkg::lane_cmd_t cmd_i,
  input  logic [31:0]         step_time_i,
  input  logic signed [31:0]  target_i,
  output logic signed [31:0]  pos_o,
  output tfpd_pkg::lane_sts_t sts_o
);

  tfpd_pkg::lane_step_e step_q, step_d;

  logic signed [31:0] pos_q, vel_q;
  logic [31:0]        errmag_q;
  logic               err_nonneg_q;
  logic [63:0]        prod_q;
  logic signed [49:0] acc_q;
  logic [48:0]        accmag_q;
  logic               accneg_q;
  logic [49:0]        dv_q;

  logic signed [32:0] err;
  logic [32:0]        err_neg;
  logic [31:0]        velabs;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;
  logic signed [49:0] t_term;
  logic signed [49:0] acc_neg;
  logic signed [51:0] dv_s, vsum;
  logic signed [33:0] dp_s, psum;
  logic [31:0]        vel_sat, pos_sat;

  // sequencer
  always_comb begin
    step_d = step_q;
    unique case (step_q)
      tfpd_pkg::LS_IDLE: if (cmd_i.start) step_d = tfpd_pkg::LS_ERR;
      tfpd_pkg::LS_ERR:  step_d = tfpd_pkg::LS_MP;
      tfpd_pkg::LS_MP:   step_d = tfpd_pkg::LS_MD;
      tfpd_pkg::LS_MD:   step_d = tfpd_pkg::LS_ACC;
      tfpd_pkg::LS_ACC:  step_d = tfpd_pkg::LS_MAG;
      tfpd_pkg::LS_MAG:  step_d = tfpd_pkg::LS_DVL;
      tfpd_pkg::LS_DVL:  step_d = tfpd_pkg::LS_DVH;
      tfpd_pkg::LS_DVH:  step_d = tfpd_pkg::LS_VEL;
      tfpd_pkg::LS_VEL:  step_d = tfpd_pkg::LS_DP;
      tfpd_pkg::LS_DP:   step_d = tfpd_pkg::LS_POS;
      tfpd_pkg::LS_POS:  step_d = tfpd_pkg::LS_IDLE;
      default:           step_d = tfpd_pkg::LS_IDLE;
    endcase
  end

  always_comb begin
    sts_o.busy = (step_q != tfpd_pkg::LS_IDLE);
    sts_o.done = (step_q == tfpd_pkg::LS_POS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= tfpd_pkg::LS_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  // shared multiplier
  assign err     = $signed({pos_q[31], pos_q}) - $signed({target_i[31], target_i});
  assign err_neg = -err;
  assign velabs  = vel_q[31] ? (~vel_q + 32'sd1) : vel_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step_q)
      tfpd_pkg::LS_MP: begin
        mul_a = errmag_q;
        mul_b = cmd_i.kp;
      end
      tfpd_pkg::LS_MD: begin
        mul_a = velabs;
        mul_b = cmd_i.kd;
      end
      tfpd_pkg::LS_DVL: begin
        mul_a = accmag_q[31:0];
        mul_b = step_time_i;
      end
      tfpd_pkg::LS_DVH: begin
        mul_a = {15'd0, accmag_q[48:32]};
        mul_b = step_time_i;
      end
      tfpd_pkg::LS_DP: begin
        mul_a = velabs;
        mul_b = step_time_i;
      end
      default: ;
    endcase
  end

  assign mul_p   = {32'd0, mul_a} * {32'd0, mul_b};
  assign t_term  = $signed({2'b00, prod_q[63:16]});
  assign acc_neg = -acc_q;

  // saturating updates of velocity and position
  always_comb begin
    dv_s = $signed({2'b00, dv_q});
    vsum = $signed({{20{vel_q[31]}}, vel_q}) + (accneg_q ? -dv_s : dv_s);
    if (!vsum[51] && (|vsum[50:31])) begin
      vel_sat = tfpd_pkg::POS_MAX;
    end else if (vsum[51] && !(&vsum[50:31])) begin
      vel_sat = tfpd_pkg::POS_MIN;
    end else begin
      vel_sat = vsum[31:0];
    end
    dp_s = $signed({2'b00, prod_q[63:32]});
    psum = $signed({{2{pos_q[31]}}, pos_q}) + (vel_q[31] ? -dp_s : dp_s);
    if (!psum[33] && (|psum[32:31])) begin
      pos_sat = tfpd_pkg::POS_MAX;
    end else if (psum[33] && !(&psum[32:31])) begin
      pos_sat = tfpd_pkg::POS_MIN;
    end else begin
      pos_sat = psum[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      vel_q <= '0;
    end else begin
      if (step_q == tfpd_pkg::LS_VEL) vel_q <= vel_sat;
      if (step_q == tfpd_pkg::LS_POS) pos_q <= pos_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (step_q)
      tfpd_pkg::LS_ERR: begin
        errmag_q     <= err[32] ? err_neg[31:0] : err[31:0];
        err_nonneg_q <= ~err[32];
      end
      tfpd_pkg::LS_MP: prod_q <= mul_p;
      tfpd_pkg::LS_MD: begin
        acc_q  <= err_nonneg_q ? -t_term : t_term;
        prod_q <= mul_p;
      end
      tfpd_pkg::LS_ACC: acc_q <= acc_q + (vel_q[31] ? t_term : -t_term);
      tfpd_pkg::LS_MAG: begin
        accmag_q <= acc_q[49] ? acc_neg[48:0] : acc_q[48:0];
        accneg_q <= acc_q[49];
      end
      tfpd_pkg::LS_DVL: prod_q <= mul_p;
      tfpd_pkg::LS_DVH: dv_q <= mul_p[49:0] + {18'd0, prod_q[63:32]};
      tfpd_pkg::LS_DP:  prod_q <= mul_p;
      default: ;
    endcase
  end

  assign pos_o = pos_q;

endmodule

/* rtl/core/tfpd_target.sv */
module tfpd_target (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tfpd_pkg::tgt_cmd_t cmd_i,
  input  logic signed [31:0] target_right_i,
  input  logic signed [31:0] target_left_i,
  input  logic signed [31:0] pos_right_i,
  input  logic signed [31:0] pos_left_i,
  input  logic [30:0]        limit_i,
  input  logic [30:0]        margin_i,
  input  logic               axis_is_x_i,
  output logic signed [31:0] tgt_right_o,
  output logic signed [31:0] tgt_left_o,
  output tfpd_pkg::tgt_sts_t sts_o
);

  tfpd_pkg::tgt_step_e step_q, step_d;

  logic signed [31:0] rt_q, lt_q;
  logic signed [31:0] rc_q, lc_q;
  logic signed [33:0] nt_q;

  logic signed [32:0] lim_s;
  logic signed [31:0] rc_d, lc_d;
  logic signed [33:0] r_adj, l_adj, rc_x, lc_x, m_x, s_x;
  logic               overlap;

  always_comb begin
    step_d = step_q;
    unique case (step_q)
      tfpd_pkg::TS_IDLE:  if (cmd_i.load) step_d = tfpd_pkg::TS_CLAMP;
      tfpd_pkg::TS_CLAMP: step_d = tfpd_pkg::TS_SEP;
      tfpd_pkg::TS_SEP:   step_d = tfpd_pkg::TS_ADJ;
      tfpd_pkg::TS_ADJ:   step_d = tfpd_pkg::TS_IDLE;
      default:            step_d = tfpd_pkg::TS_IDLE;
    endcase
  end

  always_comb begin
    sts_o.busy = (step_q != tfpd_pkg::TS_IDLE);
    sts_o.done = (step_q == tfpd_pkg::TS_ADJ);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= tfpd_pkg::TS_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  // clamp to the position limit
  assign lim_s = $signed({2'b00, limit_i});

  always_comb begin
    if ($signed({rt_q[31], rt_q}) > lim_s) begin
      rc_d = lim_s[31:0];
    end else if ($signed({rt_q[31], rt_q}) < -lim_s) begin
      rc_d = 32'(-lim_s);
    end else begin
      rc_d = rt_q;
    end
    if ($signed({lt_q[31], lt_q}) > lim_s) begin
      lc_d = lim_s[31:0];
    end else if ($signed({lt_q[31], lt_q}) < -lim_s) begin
      lc_d = 32'(-lim_s);
    end else begin
      lc_d = lt_q;
    end
  end

  // separation rule on the x axis only, overlap when left minus right minus margin is positive
  always_comb begin
    rc_x    = $signed({{2{rc_q[31]}}, rc_q});
    lc_x    = $signed({{2{lc_q[31]}}, lc_q});
    m_x     = $signed({3'b000, margin_i});
    s_x     = $signed({1'b0, nt_q[33:1]});
    overlap = axis_is_x_i && !nt_q[33] && (nt_q != '0);
    r_adj   = rc_x;
    l_adj   = lc_x;
    if (overlap) begin
      if (cmd_i.right_tracking && cmd_i.left_tracking) begin
        r_adj = rc_x + s_x;
        l_adj = lc_x - s_x;
      end else if (cmd_i.left_tracking) begin
        l_adj = rc_x + m_x;
      end else if (cmd_i.right_tracking) begin
        r_adj = lc_x - m_x;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rt_q <= '0;
      lt_q <= '0;
    end else begin
      if (cmd_i.load) begin
        if (cmd_i.right_tracking) rt_q <= target_right_i;
        if (cmd_i.left_tracking)  lt_q <= target_left_i;
      end
      if (cmd_i.copy_right) rt_q <= pos_right_i;
      if (cmd_i.copy_left)  lt_q <= pos_left_i;
      if (step_q == tfpd_pkg::TS_ADJ) begin
        rt_q <= r_adj[31:0];
        lt_q <= l_adj[31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_q == tfpd_pkg::TS_CLAMP) begin
      rc_q <= rc_d;
      lc_q <= lc_d;
    end
    if (step_q == tfpd_pkg::TS_SEP) begin
      nt_q <= $signed({{2{lc_q[31]}}, lc_q}) - $signed({{2{rc_q[31]}}, rc_q})
              - $signed({3'b000, margin_i});
    end
  end

  assign tgt_right_o = rt_q;
  assign tgt_left_o  = lt_q;

endmodule

/* rtl/core/two_foot_pd_step_tracker_core.sv */
// Two-foot PD step tracker. Each transaction on in_i carries one operation (set mode,
// set targets, tick or no-op) and gives exactly one transaction on out_o holding both
// foot positions in Q8.24. A tick runs the two feet in two identical lanes side by
// side; each lane walks its PD double integrator through ten sequenced steps on its
// one 32x32 multiplier. Set targets steps through clamp, separation and update; set
// mode and the no-op go straight to the output. A result waiting on out_o does not
// hold off the next operation; a second result waits for the output register to be
// taken. Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i; the
// user must write it only while the block is idle, which the block does not enforce.
`include "two_foot_pd_step_tracker_core_defines.svh"

module two_foot_pd_step_tracker_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  tfpd_in_if.sink     in_i,
  tfpd_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  tfpd_pkg::ctl_state_e state_q, state_d;

  logic [31:0] kp_hold_q, kd_hold_q, kp_track_q, kd_track_q, step_time_q;
  logic [30:0] pos_limit_q, margin_q;
  logic        axis_is_x_q;
  logic        right_trk_q, left_trk_q;

  logic               out_valid_q;
  logic signed [31:0] out_right_q, out_left_q;

  logic               accept, emit;
  logic               mode_right, mode_left;
  tfpd_pkg::lane_cmd_t r_cmd, l_cmd;
  tfpd_pkg::lane_sts_t r_sts, l_sts;
  tfpd_pkg::tgt_cmd_t  tgt_cmd;
  tfpd_pkg::tgt_sts_t  tgt_sts;
  logic signed [31:0] pos_right, pos_left, tgt_right, tgt_left;
  logic signed [32:0] lim_s, tr_s, tl_s;
  logic               tgt_in_lim;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_hold_q   <= tfpd_pkg::KP_HOLD_RST;
      kd_hold_q   <= tfpd_pkg::KD_HOLD_RST;
      kp_track_q  <= tfpd_pkg::KP_TRACK_RST;
      kd_track_q  <= tfpd_pkg::KD_TRACK_RST;
      step_time_q <= tfpd_pkg::STEP_TIME_RST;
      pos_limit_q <= tfpd_pkg::POSITION_LIMIT_RST;
      margin_q    <= tfpd_pkg::COLLISION_MARGIN_RST;
      axis_is_x_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tfpd_pkg::CFG_KP_HOLD:          kp_hold_q   <= cfg_data_i;
        tfpd_pkg::CFG_KD_HOLD:          kd_hold_q   <= cfg_data_i;
        tfpd_pkg::CFG_KP_TRACK:         kp_track_q  <= cfg_data_i;
        tfpd_pkg::CFG_KD_TRACK:         kd_track_q  <= cfg_data_i;
        tfpd_pkg::CFG_STEP_TIME:        step_time_q <= cfg_data_i;
        tfpd_pkg::CFG_POSITION_LIMIT:   pos_limit_q <= cfg_data_i[30:0];
        tfpd_pkg::CFG_COLLISION_MARGIN: margin_q    <= cfg_data_i[30:0];
        tfpd_pkg::CFG_AXIS_IS_X:        axis_is_x_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign in_i.ready = (state_q == tfpd_pkg::ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  // control sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tfpd_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_i.opcode)
            tfpd_pkg::OP_TICK:        state_d = tfpd_pkg::ST_TICK;
            tfpd_pkg::OP_SET_TARGETS: state_d = tfpd_pkg::ST_TGT;
            tfpd_pkg::OP_SET_MODE:    state_d = tfpd_pkg::ST_EMIT;
            tfpd_pkg::OP_NOP:         state_d = tfpd_pkg::ST_EMIT;
            default:                  state_d = tfpd_pkg::ST_EMIT;
          endcase
        end
      end
      tfpd_pkg::ST_TICK: if (r_sts.done && l_sts.done) state_d = tfpd_pkg::ST_EMIT;
      tfpd_pkg::ST_TGT:  if (tgt_sts.done) state_d = tfpd_pkg::ST_EMIT;
      tfpd_pkg::ST_EMIT: if (!out_valid_q || out_o.ready) state_d = tfpd_pkg::ST_IDLE;
      default:           state_d = tfpd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mode_right = accept && (in_i.opcode == tfpd_pkg::OP_SET_MODE) && !in_i.foot
                 && (in_i.mode != right_trk_q);
    mode_left  = accept && (in_i.opcode == tfpd_pkg::OP_SET_MODE) && in_i.foot
                 && (in_i.mode != left_trk_q);
    emit       = (state_q == tfpd_pkg::ST_EMIT) && (!out_valid_q || out_o.ready);

    r_cmd.start = accept && (in_i.opcode == tfpd_pkg::OP_TICK);
    r_cmd.kp    = right_trk_q ? kp_track_q : kp_hold_q;
    r_cmd.kd    = right_trk_q ? kd_track_q : kd_hold_q;
    l_cmd.start = accept && (in_i.opcode == tfpd_pkg::OP_TICK);
    l_cmd.kp    = left_trk_q ? kp_track_q : kp_hold_q;
    l_cmd.kd    = left_trk_q ? kd_track_q : kd_hold_q;

    tgt_cmd.load           = accept && (in_i.opcode == tfpd_pkg::OP_SET_TARGETS);
    tgt_cmd.copy_right     = mode_right && !in_i.mode;
    tgt_cmd.copy_left      = mode_left && !in_i.mode;
    tgt_cmd.right_tracking = right_trk_q;
    tgt_cmd.left_tracking  = left_trk_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tfpd_pkg::ST_IDLE;
      right_trk_q <= 1'b0;
      left_trk_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mode_right) right_trk_q <= in_i.mode;
      if (mode_left)  left_trk_q  <= in_i.mode;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // merge of both lanes into the output register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_right_q <= pos_right;
      out_left_q  <= pos_left;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.pos_right = out_right_q;
  assign out_o.pos_left  = out_left_q;

  tfpd_lane u_lane_right (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (r_cmd),
    .step_time_i (step_time_q),
    .target_i    (tgt_right),
    .pos_o       (pos_right),
    .sts_o       (r_sts)
  );

  tfpd_lane u_lane_left (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (l_cmd),
    .step_time_i (step_time_q),
    .target_i    (tgt_left),
    .pos_o       (pos_left),
    .sts_o       (l_sts)
  );

  tfpd_target u_target (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (tgt_cmd),
    .target_right_i (in_i.target_right),
    .target_left_i  (in_i.target_left),
    .pos_right_i    (pos_right),
    .pos_left_i     (pos_left),
    .limit_i        (pos_limit_q),
    .margin_i       (margin_q),
    .axis_is_x_i    (axis_is_x_q),
    .tgt_right_o    (tgt_right),
    .tgt_left_o     (tgt_left),
    .sts_o          (tgt_sts)
  );

  // targets inside the limit once the separation rule is off
  assign lim_s      = $signed({2'b00, pos_limit_q});
  assign tr_s       = $signed({tgt_right[31], tgt_right});
  assign tl_s       = $signed({tgt_left[31], tgt_left});
  assign tgt_in_lim = (tr_s <= lim_s) && (tr_s >= -lim_s) && (tl_s <= lim_s)
                      && (tl_s >= -lim_s);

  `TFPD_ASSERT_NOW(a_lanes_in_step, clk_i, rst_ni, 1'b1,
                   (r_sts.done == l_sts.done) && (r_sts.busy == l_sts.busy))
  `TFPD_ASSERT_NOW(a_lane_busy_in_tick, clk_i, rst_ni, r_sts.busy,
                   state_q == tfpd_pkg::ST_TICK)
  `TFPD_ASSERT_NEXT(a_targets_clamped, clk_i, rst_ni, tgt_sts.done && !axis_is_x_q,
                    tgt_in_lim)

endmodule
